// File: rtl/core/scbpa_pkg.sv
// Shared types, constants and reset tables for the size-class pool allocator.
// No dependencies; used by scbpa_pool and size_class_block_pool_allocator_core.
`timescale 1ns / 1ps

package scbpa_pkg;

  // Fixed geometry of the allocator
  localparam int unsigned POOLS      = 4;
  localparam int unsigned MAX_BLOCKS = 32;
  localparam int unsigned BLK_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PIDX_W     = $clog2(POOLS);
  localparam int unsigned POOL_W     = 3;
  localparam int unsigned BYTES_W    = 16;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_POOL    = 2'd0;
  localparam logic [1:0] ST_HEAP    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Register map: byte sizes first, block totals from this index on
  localparam logic [2:0] REG_TOTAL_BASE = 3'd4;

  // Pool number that stands for a heap handle
  localparam logic [POOL_W-1:0] HEAP_POOL = POOL_W'(POOLS);

  // Command word from the decision logic into one pool
  typedef struct packed {
    logic             rebuild;
    logic [CNT_W-1:0] rebuild_total;
    logic             pop;
    logic             push;
    logic [BLK_W-1:0] blk;
  } pool_cmd_t;

  // Status word from one pool back to the decision logic
  typedef struct packed {
    logic [CNT_W-1:0] depth;
    logic [CNT_W-1:0] total;
    logic [BLK_W-1:0] top_blk;
    logic             blk_marked;
  } pool_stat_t;

  function automatic logic [BYTES_W-1:0] reset_bytes(input logic [1:0] p);
    logic [BYTES_W-1:0] v;
    unique case (p)
      2'd0: v = 16'd64;
      2'd1: v = 16'd256;
      2'd2: v = 16'd1024;
      2'd3: v = 16'd4096;
    endcase
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] reset_total(input logic [1:0] p);
    logic [CNT_W-1:0] v;
    unique case (p)
      2'd0: v = 6'd32;
      2'd1: v = 6'd16;
      2'd2: v = 6'd8;
      2'd3: v = 6'd4;
    endcase
    return v;
  endfunction

  // Clamp a written block total into 1..MAX_BLOCKS
  function automatic logic [CNT_W-1:0] clamp_total(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(MAX_BLOCKS)) begin
      r = CNT_W'(MAX_BLOCKS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/scbpa_pool.sv
// One fixed-block pool: LIFO free stack of block indices, allocated marks,
// stack depth and block total. Depends on scbpa_pkg.
`timescale 1ns / 1ps

module scbpa_pool
  import scbpa_pkg::*;
#(
  parameter int unsigned POOL_ID = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pool_cmd_t  cmd,
  output pool_stat_t stat
);

  logic [BLK_W-1:0] stack_r [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] mark_r;
  logic [CNT_W-1:0] depth_r;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] depth_dec;
  logic [BLK_W-1:0] top_idx;
  logic [CNT_W-1:0] rst_total;

  assign rst_total = reset_total(2'(POOL_ID));
  assign depth_dec = depth_r - CNT_W'(1);
  assign top_idx   = depth_dec[BLK_W-1:0];

  // Status back to the decision logic
  assign stat.depth      = depth_r;
  assign stat.total      = total_r;
  assign stat.top_blk    = stack_r[top_idx];
  assign stat.blk_marked = mark_r[cmd.blk];

  // Stack, marks and depth; reset and rebuild refill the whole stack at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= rst_total;
      depth_r <= rst_total;
      mark_r  <= '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        stack_r[i] <= BLK_W'(i);
      end
    end else if (cmd.rebuild) begin
      total_r <= cmd.rebuild_total;
      depth_r <= cmd.rebuild_total;
      mark_r  <= '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        stack_r[i] <= BLK_W'(i);
      end
    end else if (cmd.pop) begin
      depth_r         <= depth_dec;
      mark_r[stack_r[top_idx]] <= 1'b1;
    end else if (cmd.push) begin
      stack_r[depth_r[BLK_W-1:0]] <= cmd.blk;
      mark_r[cmd.blk] <= 1'b0;
      depth_r         <= depth_r + CNT_W'(1);
    end
  end

endmodule

// File: rtl/core/size_class_block_pool_allocator_core.sv
// Size-class block pool allocator, top level: input and result registers,
// pool choice, sticky flags and APB register file. Depends on scbpa_pkg, scbpa_pool.
//
// Usage:
//   Command channel: an item (in_op, in_request_bytes, in_pool_number,
//   in_block_number) is taken at each clock edge where start is high and
//   busy is low. busy stays low, so a word may be issued every cycle.
//   Result channel: out_valid marks each result word for exactly one cycle,
//   after the command has passed the input register and then the pool decision
//   and stack update that feed the result register. One result per
//   command, in command order; sustained rate is one item per cycle, set by
//   the single pass through the size compares and the stack tops.
//   The receiver cannot stall; results must be taken when strobed.
//   Configuration: APB, registers at 4*i: block byte sizes of pools 0..3,
//   then block totals of pools 0..3. Writing a total rebuilds that pool's
//   free stack. Write only while no command is in flight.
//   Reset (synchronous, rst_n low): sizes 64/256/1024/4096, totals
//   32/16/8/4, all stacks full, flags clear. No clearing pass is needed.
`timescale 1ns / 1ps

module size_class_block_pool_allocator_core
  import scbpa_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic                in_op,
  input  logic [BYTES_W-1:0]  in_request_bytes,
  input  logic [POOL_W-1:0]   in_pool_number,
  input  logic [BLK_W-1:0]    in_block_number,
  // result channel
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [POOL_W-1:0]   out_granted_pool,
  output logic [BLK_W-1:0]    out_granted_block,
  output logic [CNT_W-1:0]    out_pool_in_use,
  output logic                out_full_seen,
  output logic                out_error_seen,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned NEED_W = BYTES_W + 1;

  // input register
  logic                in_valid_r;
  logic                in_op_r;
  logic [BYTES_W-1:0]  in_req_r;
  logic [POOL_W-1:0]   in_pool_r;
  logic [BLK_W-1:0]    in_blk_r;

  // configuration and flags
  logic [BYTES_W-1:0]  bytes_r [POOLS];
  logic                full_r, full_nxt;
  logic                err_r, err_nxt;

  // result register
  logic                out_valid_r;
  logic [1:0]          status_r, status_nxt;
  logic [POOL_W-1:0]   gpool_r, gpool_nxt;
  logic [BLK_W-1:0]    gblk_r, gblk_nxt;
  logic [CNT_W-1:0]    inuse_r, inuse_nxt;
  logic                full_out_r, err_out_r;

  pool_cmd_t           cmd [POOLS];
  pool_stat_t          stat [POOLS];

  logic                cfg_wr;
  logic [2:0]          cfg_idx;
  logic                cfg_is_total;
  logic [PIDX_W-1:0]   cfg_sel;
  logic [2:0]          cfg_off;
  logic [CNT_W-1:0]    cfg_total;

  logic [NEED_W-1:0]   need;
  logic [POOLS-1:0]    fits;
  logic                found;
  logic [PIDX_W-1:0]   fidx;
  logic                free_ok;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // APB decode
  assign cfg_wr       = psel && penable && pwrite;
  assign cfg_idx      = paddr[4:2];
  assign cfg_is_total = (cfg_idx >= REG_TOTAL_BASE);
  assign cfg_off      = cfg_is_total ? (cfg_idx - REG_TOTAL_BASE) : cfg_idx;
  assign cfg_sel      = cfg_off[PIDX_W-1:0];
  assign cfg_total    = clamp_total(pwdata[CNT_W-1:0]);

  // register read-back
  always_comb begin
    if (cfg_is_total) begin
      prdata = {{(32-CNT_W){1'b0}}, stat[cfg_sel].total};
    end else begin
      prdata = {{(32-BYTES_W){1'b0}}, bytes_r[cfg_sel]};
    end
  end

  // byte size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < POOLS; p++) begin
        bytes_r[p] <= reset_bytes(2'(p));
      end
    end else if (cfg_wr && !cfg_is_total) begin
      bytes_r[cfg_sel] <= pwdata[BYTES_W-1:0];
    end
  end

  // command input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    if (start && !busy) begin
      in_op_r   <= in_op;
      in_req_r  <= in_request_bytes;
      in_pool_r <= in_pool_number;
      in_blk_r  <= in_block_number;
    end
  end

  // size compares
  assign need = {1'b0, in_req_r} + NEED_W'(HEADER_BYTES);
  always_comb begin
    for (int p = 0; p < POOLS; p++) begin
      fits[p] = (need <= {1'b0, bytes_r[p]});
    end
  end

  assign fidx    = in_pool_r[PIDX_W-1:0];
  assign free_ok = (CNT_W'(in_blk_r) < stat[fidx].total) && stat[fidx].blk_marked &&
                   (stat[fidx].depth < stat[fidx].total);

  // pool choice and stack commands
  always_comb begin
    status_nxt = ST_HEAP;
    gpool_nxt  = HEAP_POOL;
    gblk_nxt   = '0;
    inuse_nxt  = '0;
    full_nxt   = full_r;
    err_nxt    = err_r;
    found      = 1'b0;
    for (int p = 0; p < POOLS; p++) begin
      cmd[p].rebuild       = cfg_wr && cfg_is_total && (cfg_sel == PIDX_W'(p));
      cmd[p].rebuild_total = cfg_total;
      cmd[p].pop           = 1'b0;
      cmd[p].push          = 1'b0;
      cmd[p].blk           = in_blk_r;
    end
    if (in_valid_r) begin
      if (in_op_r == OP_ALLOC) begin
        // first fitting pool with a free block serves; empty ones on the way set the full flag
        for (int p = 0; p < POOLS; p++) begin
          if (!found && fits[p]) begin
            if (stat[p].depth != '0) begin
              found      = 1'b1;
              cmd[p].pop = 1'b1;
              status_nxt = ST_POOL;
              gpool_nxt  = POOL_W'(p);
              gblk_nxt   = stat[p].top_blk;
              inuse_nxt  = stat[p].total - stat[p].depth + CNT_W'(1);
            end else begin
              full_nxt = 1'b1;
            end
          end
        end
      end else if (in_pool_r == HEAP_POOL) begin
        // heap handle passes through
      end else if (in_pool_r > HEAP_POOL) begin
        err_nxt    = 1'b1;
        status_nxt = ST_INVALID;
        gpool_nxt  = in_pool_r;
        gblk_nxt   = in_blk_r;
      end else begin
        gpool_nxt = in_pool_r;
        gblk_nxt  = in_blk_r;
        if (free_ok) begin
          cmd[fidx].push = 1'b1;
          status_nxt     = ST_POOL;
          inuse_nxt      = stat[fidx].total - stat[fidx].depth - CNT_W'(1);
        end else begin
          err_nxt    = 1'b1;
          status_nxt = ST_INVALID;
          inuse_nxt  = stat[fidx].total - stat[fidx].depth;
        end
      end
    end
  end

  // pools
  for (genvar g = 0; g < POOLS; g++) begin : g_pool
    scbpa_pool #(
      .POOL_ID (g)
    ) u_pool (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[g]),
      .stat  (stat[g])
    );
  end

  // sticky flags and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      full_r      <= full_nxt;
      err_r       <= err_nxt;
      out_valid_r <= in_valid_r;
    end
    if (in_valid_r) begin
      status_r   <= status_nxt;
      gpool_r    <= gpool_nxt;
      gblk_r     <= gblk_nxt;
      inuse_r    <= inuse_nxt;
      full_out_r <= full_nxt;
      err_out_r  <= err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_pool  = gpool_r;
  assign out_granted_block = gblk_r;
  assign out_pool_in_use   = inuse_r;
  assign out_full_seen     = full_out_r;
  assign out_error_seen    = err_out_r;

`ifndef SYNTHESIS
  // a result word only follows a command taken through the input and result registers
  a_out_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without a command");

  // an invalid free always reports the error flag
  a_invalid_sets_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_INVALID) |-> out_error_seen)
    else $error("invalid free without error flag");

  // heap results carry the heap handle and nothing else
  a_heap_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_HEAP) |->
      (out_granted_pool == HEAP_POOL && out_granted_block == '0 &&
       out_pool_in_use == '0))
    else $error("malformed heap result");

  // full flag never drops outside reset
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(full_r)) |-> full_r)
    else $error("full flag cleared");

  // no pool stack ever holds more than its total
  for (genvar a = 0; a < POOLS; a++) begin : g_depth_chk
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
      stat[a].depth <= stat[a].total)
      else $error("stack depth above block total");
  end
`endif

endmodule
